// File: src/lz77wc_pkg.sv
// shared types, widths and constants for the lz77 window copy decoder
package lz77wc_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int SYMBOL_BITS_DEF   = 16;
    localparam int MAX_RUN_DEF       = 63;

    localparam int SYM_FIELD_W = 16;
    localparam int POS_W       = 32;
    localparam int OFFSET_W    = 12;
    localparam int RUN_W       = 6;
    localparam int WIDTH_W     = 12;
    // distance from window start to write position never exceeds 4095 + 1 + 63
    localparam int SPAN_W      = 13;
    localparam int LAG_W       = SPAN_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_LAG_LIMIT   = 1'b0;
    localparam logic [WIDTH_W-1:0] LAG_LIMIT_RESET = 12'hFFF;

    typedef struct packed {
        logic                   frame_start;
        logic [OFFSET_W-1:0]    offset_from_window;
        logic [RUN_W-1:0]       run_length;
        logic [SYM_FIELD_W-1:0] literal_symbol;
    } item_t;

    typedef struct packed {
        logic [SYM_FIELD_W-1:0] symbol;
        logic [POS_W-1:0]       position;
        logic                   is_literal;
        logic                   last_of_item;
        logic                   bad_reference;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0]       pos;
        logic                   is_literal;
        logic                   last;
        logic                   bad;
        logic                   fwd;
        logic [SYM_FIELD_W-1:0] lit_sym;
    } issue_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } seq_state_t;

endpackage

// File: src/lz77wc_history.sv
// history memory: one write port, one registered read port
module lz77wc_history import lz77wc_pkg::*; #(
    parameter int DEPTH = HISTORY_DEPTH_DEF,
    parameter int WIDTH = SYMBOL_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lz77wc_seq.sv
// sequencer: takes a triplet, walks the copy run and the literal, issues history reads
module lz77wc_seq import lz77wc_pkg::*; #(
    parameter int DEPTH   = HISTORY_DEPTH_DEF,
    parameter int MAX_RUN = MAX_RUN_DEF,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    input  logic [WIDTH_W-1:0] lag_limit,
    input  logic               b_ready,
    output logic               issue_valid,
    output issue_t             issue,
    output logic               re,
    output logic [AW-1:0]      raddr
);

    localparam logic [POS_W-1:0] DEPTH_W   = POS_W'(DEPTH);
    localparam logic [RUN_W-1:0] MAX_RUN_C = RUN_W'(MAX_RUN);

    seq_state_t             state_reg, state_next;
    logic [POS_W-1:0]       wp_reg, wp_next;
    logic [SPAN_W-1:0]      span_reg, span_next;
    logic [RUN_W-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]          src_reg, src_next;
    logic                   bad_reg, bad_next;
    logic                   fwd_reg, fwd_next;
    logic [SYM_FIELD_W-1:0] lit_reg, lit_next;

    logic                   accept;
    logic                   fire;
    logic                   fire_lit;
    logic [POS_W-1:0]       wp0;
    logic [SPAN_W-1:0]      span0;
    logic [LAG_W-1:0]       lag;
    logic                   lag_ok;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign fire       = (state_reg == S_RUN) && b_ready;
    assign fire_lit   = (cnt_reg == '0);

    assign wp0    = item.frame_start ? '0 : wp_reg;
    assign span0  = item.frame_start ? '0 : span_reg;
    assign lag    = {1'b0, span0} - LAG_W'(item.offset_from_window);
    assign lag_ok = !lag[LAG_W-1] && (lag != '0) && (POS_W'(lag) <= DEPTH_W);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        span_next  = span_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        bad_next   = bad_reg;
        fwd_next   = fwd_reg;
        lit_next   = lit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    wp_next    = wp0;
                    span_next  = span0;
                    cnt_next   = (item.run_length > MAX_RUN_C) ? MAX_RUN_C : item.run_length;
                    src_next   = wp0[AW-1:0] - AW'(lag);
                    bad_next   = !lag_ok;
                    fwd_next   = (lag == LAG_W'(1));
                    lit_next   = item.literal_symbol;
                end
            end
            S_RUN:
            begin
                if (fire)
                begin
                    wp_next = wp_reg + POS_W'(1);
                    if (fire_lit)
                    begin
                        state_next = S_IDLE;
                        if (span_reg > SPAN_W'(lag_limit))
                        begin
                            span_next = SPAN_W'(lag_limit) + SPAN_W'(1);
                        end
                        else
                        begin
                            span_next = span_reg + SPAN_W'(1);
                        end
                    end
                    else
                    begin
                        cnt_next  = cnt_reg - RUN_W'(1);
                        src_next  = src_reg + AW'(1);
                        span_next = span_reg + SPAN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            span_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            span_reg  <= span_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        bad_reg <= bad_next;
        fwd_reg <= fwd_next;
        lit_reg <= lit_next;
    end

    assign issue_valid      = fire;
    assign issue.pos        = wp_reg;
    assign issue.is_literal = fire_lit;
    assign issue.last       = fire_lit;
    assign issue.bad        = bad_reg && !fire_lit;
    assign issue.fwd        = fwd_reg;
    assign issue.lit_sym    = lit_reg;

    assign re    = fire && !fire_lit;
    assign raddr = src_reg;

endmodule

// File: src/lz77wc_emit.sv
// emit stage: picks the symbol, writes it back to history, holds the result register
module lz77wc_emit import lz77wc_pkg::*; #(
    parameter int DEPTH = HISTORY_DEPTH_DEF,
    parameter int SYM_W = SYMBOL_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             issue_valid,
    input  issue_t           issue,
    output logic             b_ready,
    input  logic [SYM_W-1:0] rdata,
    output logic             we,
    output logic [AW-1:0]    waddr,
    output logic [SYM_W-1:0] wdata,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result_data
);

    logic             b_valid_reg;
    issue_t           b_reg;
    logic [SYM_W-1:0] last_sym_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic             free;
    logic             advance;
    logic [SYM_W-1:0] sym_now;

    assign free    = !out_valid_reg || result_ready;
    assign advance = b_valid_reg && free;
    assign b_ready = !b_valid_reg || advance;

    always_comb
    begin
        if (b_reg.is_literal)
        begin
            sym_now = b_reg.lit_sym[SYM_W-1:0];
        end
        else if (b_reg.bad)
        begin
            sym_now = '0;
        end
        else if (b_reg.fwd)
        begin
            sym_now = last_sym_reg;
        end
        else
        begin
            sym_now = rdata;
        end
    end

    assign we    = advance;
    assign waddr = b_reg.pos[AW-1:0];
    assign wdata = sym_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue_valid)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                b_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_valid)
        begin
            b_reg <= issue;
        end
        if (advance)
        begin
            last_sym_reg          <= sym_now;
            out_reg.symbol        <= SYM_FIELD_W'(sym_now);
            out_reg.position      <= b_reg.pos;
            out_reg.is_literal    <= b_reg.is_literal;
            out_reg.last_of_item  <= b_reg.last;
            out_reg.bad_reference <= b_reg.bad;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

// File: src/lz77_window_copy_decoder.sv
// top level of the lz77 window copy decoder: register port and datapath wiring
//
// Each accepted triplet yields run_length + 1 result transfers: the copied
// symbols, then the literal. When results are taken at once, the triplet is
// taken in, then one symbol issues per cycle, with a single history read
// issued per copied symbol; a new triplet is taken only after its literal.
// A source one place behind the write position is served from the last
// written symbol. The history memory is not cleared after reset; its depth
// must be a power of two. The lag limit register must be written through the
// register port only while no triplet is in flight; the block does not enforce it.
module lz77_window_copy_decoder import lz77wc_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF,
    parameter int MAX_RUN       = MAX_RUN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item_data,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result_data
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int SYM_W = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;

    logic [WIDTH_W-1:0] lag_limit_reg;
    logic               reg_hit;

    logic               b_ready;
    logic               issue_valid;
    issue_t             issue;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [SYM_W-1:0]   rdata;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [SYM_W-1:0]   wdata;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_LAG_LIMIT);
    assign prdata  = reg_hit ? PDATA_W'(lag_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_limit_reg <= LAG_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            lag_limit_reg <= pwdata[WIDTH_W-1:0];
        end
    end

    lz77wc_seq #(
        .DEPTH   (HISTORY_DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_data),
        .lag_limit    (lag_limit_reg),
        .b_ready      (b_ready),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .re           (re),
        .raddr        (raddr)
    );

    lz77wc_history #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (SYM_W)
    ) u_history (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    lz77wc_emit #(
        .DEPTH (HISTORY_DEPTH),
        .SYM_W (SYM_W)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .b_ready      (b_ready),
        .rdata        (rdata),
        .we           (we),
        .waddr        (waddr),
        .wdata        (wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// File: src/lz77wc_checker.sv
// port-level checks for the lz77 window copy decoder, bound to the top level
module lz77wc_checker import lz77wc_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    logic item_xfer;
    logic result_xfer;

    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid && result_ready;

    // a waiting result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // one triplet at a time
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> !item_ready)
        else $error("triplet taken while previous still in flight");

    // results of one triplet sit at consecutive positions
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer && !result_data.last_of_item |=>
            !result_xfer || (result_data.position == $past(result_data.position) + 32'd1))
        else $error("position did not advance by one within a triplet");

    // the copied run shares one reference check, the literal is never flagged
    a_bad_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer && !result_data.last_of_item |=>
            !result_xfer ||
            (result_data.is_literal ? !result_data.bad_reference
                : (result_data.bad_reference == $past(result_data.bad_reference))))
        else $error("bad reference flag changed within a triplet");

endmodule

bind lz77_window_copy_decoder lz77wc_checker u_lz77wc_checker (.*);
